### rtl/imm_pkg.sv
// Types and constants shared by the integer matrix multiply block.
// No dependencies; every other file refers to this package by scoped names.
package imm_pkg;

    localparam int ELEM_W = 16;
    localparam int ACC_W  = 32;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_START  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_ERR
    } t_state;

    typedef struct packed {
        t_opcode                    opcode;
        logic [IDX_W-1:0]           row_index;
        logic [IDX_W-1:0]           col_index;
        logic signed [ELEM_W-1:0]   element;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]           out_row;
        logic [IDX_W-1:0]           out_col;
        logic signed [ACC_W-1:0]    product_value;
        logic                       last;
        logic                       dim_error;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] inner;
        logic [DIM_W-1:0] cols;
    } t_dims;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
        logic             last;
    } t_beat;

    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [ACC_W-1:0] value;
        logic                    last;
    } t_done;

endpackage

### rtl/imm_ram.sv
// Element store: one write port and one registered read port.
// Depends on imm_pkg for the element width.
module imm_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [ADDR_W-1:0]                 i_wr_addr,
    input  logic signed [imm_pkg::ELEM_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [ADDR_W-1:0]                 i_rd_addr,
    output logic signed [imm_pkg::ELEM_W-1:0] o_rd_data
);

    logic signed [imm_pkg::ELEM_W-1:0] r_mem [DEPTH];
    logic signed [imm_pkg::ELEM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/imm_mac.sv
// Multiply-accumulate pipeline: align read data, multiply, accumulate.
// Depends on imm_pkg for the beat and completion types.
module imm_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  imm_pkg::t_beat                    i_beat,
    input  logic signed [imm_pkg::ELEM_W-1:0] i_a,
    input  logic signed [imm_pkg::ELEM_W-1:0] i_b,
    output imm_pkg::t_done                    o_done
);

    imm_pkg::t_beat                   r_beat1;
    imm_pkg::t_beat                   r_beat2;
    logic signed [imm_pkg::ACC_W-1:0] r_prod;
    logic signed [imm_pkg::ACC_W-1:0] r_acc;
    logic signed [imm_pkg::ACC_W-1:0] n_acc;
    logic                             r_done_valid;
    logic [imm_pkg::IDX_W-1:0]        r_done_row;
    logic [imm_pkg::IDX_W-1:0]        r_done_col;
    logic                             r_done_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat1      <= '0;
            r_beat2      <= '0;
            r_done_valid <= 1'b0;
        end else begin
            r_beat1      <= i_beat;
            r_beat2      <= r_beat1;
            r_done_valid <= r_beat2.valid && r_beat2.lastk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_beat1.valid) begin
            r_prod <= i_a * i_b;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (r_beat2.valid) begin
            n_acc = (r_beat2.first ? '0 : r_acc) + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (r_beat2.valid && r_beat2.lastk) begin
            r_done_row  <= r_beat2.row;
            r_done_col  <= r_beat2.col;
            r_done_last <= r_beat2.last;
        end
    end

    always_comb begin
        o_done.valid = r_done_valid;
        o_done.row   = r_done_row;
        o_done.col   = r_done_col;
        o_done.value = r_acc;
        o_done.last  = r_done_last;
    end

endmodule

### rtl/imm_seq.sv
// Run sequencer: walks rows, columns and the inner index, issues store reads
// and holds the result register. Depends on imm_pkg.
module imm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_match,
    input  imm_pkg::t_dims      i_dims,
    input  imm_pkg::t_done      i_done,
    input  logic                i_out_stall,
    output logic                o_busy,
    output imm_pkg::t_beat      o_beat,
    output logic                o_out_valid,
    output imm_pkg::t_out_item  o_out
);

    imm_pkg::t_state           r_state;
    imm_pkg::t_state           n_state;
    imm_pkg::t_dims            r_dims;
    imm_pkg::t_dims            n_dims;
    logic [imm_pkg::IDX_W-1:0] r_i;
    logic [imm_pkg::IDX_W-1:0] n_i;
    logic [imm_pkg::IDX_W-1:0] r_j;
    logic [imm_pkg::IDX_W-1:0] n_j;
    logic [imm_pkg::IDX_W-1:0] r_k;
    logic [imm_pkg::IDX_W-1:0] n_k;
    logic                      r_out_valid;
    logic                      n_out_valid;
    imm_pkg::t_out_item        r_out;
    imm_pkg::t_out_item        n_out;
    logic                      out_free;
    logic                      issue;
    logic                      k_last;
    logic                      j_last;
    logic                      i_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign k_last   = {1'b0, r_k} == r_dims.inner - imm_pkg::DIM_W'(1);
    assign j_last   = {1'b0, r_j} == r_dims.cols - imm_pkg::DIM_W'(1);
    assign i_last   = {1'b0, r_i} == r_dims.rows - imm_pkg::DIM_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            imm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = i_match ? imm_pkg::S_ISSUE : imm_pkg::S_ERR;
                end
            end
            imm_pkg::S_ISSUE: begin
                if (issue && k_last) begin
                    n_state = imm_pkg::S_DRAIN;
                end
            end
            imm_pkg::S_DRAIN: begin
                if (i_done.valid) begin
                    n_state = i_done.last ? imm_pkg::S_IDLE : imm_pkg::S_ISSUE;
                end
            end
            imm_pkg::S_ERR: begin
                if (out_free) begin
                    n_state = imm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = imm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy       = r_state != imm_pkg::S_IDLE;
        issue        = (r_state == imm_pkg::S_ISSUE) && (r_k != '0 || out_free);
        o_beat.valid = issue;
        o_beat.first = r_k == '0;
        o_beat.lastk = k_last;
        o_beat.row   = r_i;
        o_beat.col   = r_j;
        o_beat.k     = r_k;
        o_beat.last  = i_last && j_last;
        o_out_valid  = r_out_valid;
        o_out        = r_out;
    end

    always_comb begin
        n_dims      = r_dims;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (r_state == imm_pkg::S_IDLE && i_start) begin
            n_dims = i_dims;
            n_i    = '0;
            n_j    = '0;
            n_k    = '0;
        end
        if (issue) begin
            n_k = k_last ? '0 : r_k + imm_pkg::IDX_W'(1);
        end
        if (r_state == imm_pkg::S_DRAIN && i_done.valid) begin
            if (j_last) begin
                n_j = '0;
                n_i = r_i + imm_pkg::IDX_W'(1);
            end else begin
                n_j = r_j + imm_pkg::IDX_W'(1);
            end
            n_out_valid         = 1'b1;
            n_out.out_row       = i_done.row;
            n_out.out_col       = i_done.col;
            n_out.product_value = i_done.value;
            n_out.last          = i_done.last;
            n_out.dim_error     = 1'b0;
        end
        if (r_state == imm_pkg::S_ERR && out_free) begin
            n_out_valid         = 1'b1;
            n_out.out_row       = '0;
            n_out.out_col       = '0;
            n_out.product_value = '0;
            n_out.last          = 1'b1;
            n_out.dim_error     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imm_pkg::S_IDLE;
            r_dims      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dims      <= n_dims;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTH
    a_done_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done.valid |-> out_free)
        else $error("element completed while the result register is occupied");

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done.valid |-> r_state == imm_pkg::S_DRAIN)
        else $error("element completed outside the drain phase");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.dim_error |-> r_out.last)
        else $error("dimension error result not marked last");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == imm_pkg::S_ISSUE |-> {1'b0, r_k} < r_dims.inner)
        else $error("inner index beyond the inner dimension");
`endif

endmodule

### rtl/integer_matrix_multiply.sv
// Integer matrix multiply, top level: configuration registers, load decode,
// the two element stores, the sequencer and the MAC pipeline. Uses imm_pkg.
// Loads of A or B entries are taken one per cycle while no run is in progress
// and give no result. A start runs the whole product C = A * B with the input
// stalled until the run has finished issuing and draining: each element of C
// takes inner-dimension reads from the single read port of each store, then
// passes through read, multiply and accumulate before the next element issues;
// output-side stalls lengthen the run. Elements leave in row-major order and
// the final one is marked last; a mismatched inner dimension gives a single
// error result instead.
module integer_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  imm_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output imm_pkg::t_out_item            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]     i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [imm_pkg::DIM_W-1:0]         r_a_rows;
    logic [imm_pkg::DIM_W-1:0]         r_a_cols;
    logic [imm_pkg::DIM_W-1:0]         r_b_rows;
    logic [imm_pkg::DIM_W-1:0]         r_b_cols;
    imm_pkg::t_dims                    dims;
    logic [imm_pkg::DIM_W-1:0]         b_rows_used;
    logic                              busy;
    logic                              in_accept;
    logic                              in_range;
    logic                              wr_a;
    logic                              wr_b;
    logic                              start;
    logic [ADDR_W-1:0]                 wr_addr;
    logic [ADDR_W-1:0]                 rd_a_addr;
    logic [ADDR_W-1:0]                 rd_b_addr;
    logic signed [imm_pkg::ELEM_W-1:0] a_data;
    logic signed [imm_pkg::ELEM_W-1:0] b_data;
    imm_pkg::t_beat                    beat;
    imm_pkg::t_done                    done;

    function automatic logic [imm_pkg::DIM_W-1:0] used_dim(
        input logic [imm_pkg::DIM_W-1:0] v
    );
        logic [imm_pkg::DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = imm_pkg::DIM_W'(1);
        end else if (v > imm_pkg::DIM_W'(MAX_DIM)) begin
            r = imm_pkg::DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= imm_pkg::DIM_W'(1);
            r_a_cols <= imm_pkg::DIM_W'(1);
            r_b_rows <= imm_pkg::DIM_W'(1);
            r_b_cols <= imm_pkg::DIM_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (imm_pkg::t_cfg_idx'(i_cfg_index))
                imm_pkg::CFG_A_ROWS: r_a_rows <= i_cfg_data;
                imm_pkg::CFG_A_COLS: r_a_cols <= i_cfg_data;
                imm_pkg::CFG_B_ROWS: r_b_rows <= i_cfg_data;
                imm_pkg::CFG_B_COLS: r_b_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        dims.rows   = used_dim(r_a_rows);
        dims.inner  = used_dim(r_a_cols);
        dims.cols   = used_dim(r_b_cols);
        b_rows_used = used_dim(r_b_rows);
    end

    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_range   = ({1'b0, i_in.row_index} < imm_pkg::DIM_W'(MAX_DIM))
                     && ({1'b0, i_in.col_index} < imm_pkg::DIM_W'(MAX_DIM));
    assign wr_a       = in_accept && in_range && (i_in.opcode == imm_pkg::OP_LOAD_A);
    assign wr_b       = in_accept && in_range && (i_in.opcode == imm_pkg::OP_LOAD_B);
    assign start      = in_accept && (i_in.opcode == imm_pkg::OP_START);

    assign wr_addr   = ADDR_W'(int'(i_in.row_index) * MAX_DIM + int'(i_in.col_index));
    assign rd_a_addr = ADDR_W'(int'(beat.row) * MAX_DIM + int'(beat.k));
    assign rd_b_addr = ADDR_W'(int'(beat.k) * MAX_DIM + int'(beat.col));

    imm_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.element),
        .i_rd_en   (beat.valid),
        .i_rd_addr (rd_a_addr),
        .o_rd_data (a_data)
    );

    imm_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.element),
        .i_rd_en   (beat.valid),
        .i_rd_addr (rd_b_addr),
        .o_rd_data (b_data)
    );

    imm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_match     (dims.inner == b_rows_used),
        .i_dims      (dims),
        .i_done      (done),
        .i_out_stall (i_out_stall),
        .o_busy      (busy),
        .o_beat      (beat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    imm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .i_a     (a_data),
        .i_b     (b_data),
        .o_done  (done)
    );

endmodule
